### src/prq_pkg.sv
// Package for the palindrome radius query core.
// Holds the sequencer state type and the input kind and status codes; no dependencies.
`default_nettype none
package prq_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BINIT,
        ST_BMIR,
        ST_BMWAIT,
        ST_BEXP,
        ST_BCMP,
        ST_BWRITE,
        ST_QREAD,
        ST_QWAIT,
        ST_QOUT
    } prq_state_t;

    localparam logic       FUNC_LOAD  = 1'b0;
    localparam logic       FUNC_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_BEYOND = 2'd2;

    localparam int SPAN_W  = 11;
    localparam int INDEX_W = 10;

endpackage
`default_nettype wire

### src/prq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the text copies and the radius store.
`default_nettype none
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### src/palindrome_radius_query_core.sv
// Palindrome radius query core: byte loads, on-demand Manacher pass, substring queries.
// A load is taken in the idle state, which the core keeps. A query on ready radii goes through
// the radius read, wait and output states, an empty or out-of-range one straight to output, which
// waits for a free output register. The first query after loads runs the Manacher pass first:
// per padded position a mirror check and read, separator steps, byte pair compares and a write.
// aresetn (synchronous, active low) clears length, ready flag and control; memories keep contents.
`default_nettype none
module palindrome_radius_query_core
    import prq_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // text_byte[7:0], range_start[17:8], range_end[27:18]
    input  wire logic [1:0]  s_tuser,   // func[0], first_byte[1]
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // is_palindrome[0], centre_span[11:1], query_status[13:12]
);

    // Width of the loaded length (0..MAX_LEN), the text address, the padded index
    // (0..2*MAX_LEN) and the stored radius count (up to MAX_LEN+1).
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int TADDR_W = $clog2(MAX_LEN);
    localparam int PDEPTH  = 2 * MAX_LEN + 1;
    localparam int PAD_W   = $clog2(PDEPTH);
    localparam int IDX_W   = PAD_W + 1;
    localparam int RAD_W   = $clog2(MAX_LEN + 2);
    localparam int CMP_W   = LEN_W + RAD_W + INDEX_W + 2;

    // Input field unpacking.
    logic               in_func;
    logic               in_first;
    logic [7:0]         in_byte;
    logic [INDEX_W-1:0] in_start;
    logic [INDEX_W-1:0] in_end;

    assign in_func  = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_byte  = s_tdata[7:0];
    assign in_start = s_tdata[17:8];
    assign in_end   = s_tdata[27:18];

    // Sequencer and datapath registers.
    prq_state_t         state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ready_reg, ready_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [INDEX_W-1:0] l_reg, l_next;
    logic [INDEX_W-1:0] r_reg, r_next;
    logic               res_pal_reg, res_pal_next;
    logic [SPAN_W-1:0]  res_span_reg, res_span_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_data_reg, m_data_next;

    // Memory ports.
    logic               txt_wr_en;
    logic [TADDR_W-1:0] txt_wr_addr;
    logic               txt_rd_en;
    logic [TADDR_W-1:0] txt_rd_addr_a, txt_rd_addr_b;
    logic [7:0]         txt_rd_a, txt_rd_b;
    logic               rad_wr_en;
    logic [PAD_W-1:0]   rad_wr_addr;
    logic [RAD_W-1:0]   rad_wr_data;
    logic               rad_rd_en;
    logic [PAD_W-1:0]   rad_rd_addr;
    logic [RAD_W-1:0]   rad_rd_data;

    // Derived values.
    logic [IDX_W-1:0]   pad_len;       // 2*len+1
    logic [IDX_W-1:0]   pos_lo;        // i-k
    logic [IDX_W-1:0]   pos_hi;        // i+k
    logic [IDX_W-1:0]   mirror_idx;
    logic [IDX_W-1:0]   room;          // hi-i
    logic [IDX_W-1:0]   mirror_k;
    logic [INDEX_W:0]   lr_sum;
    logic [INDEX_W+1:0] q_pos;
    logic [RAD_W-1:0]   longest;
    logic [INDEX_W:0]   q_width;
    logic               out_free;

    assign pad_len    = IDX_W'({len_reg, 1'b1});
    assign pos_lo     = i_reg - k_reg;
    assign pos_hi     = i_reg + k_reg;
    assign mirror_idx = lo_reg + hi_reg - i_reg;
    assign room       = hi_reg - i_reg;
    assign mirror_k   = (room < IDX_W'(rad_rd_data)) ? room : IDX_W'(rad_rd_data);

    // Centre c = (l+r)/2 maps to padded 2c+1, or 2c+2 for an even-length range.
    assign lr_sum  = {1'b0, l_reg} + {1'b0, r_reg};
    assign q_pos   = {1'b0, lr_sum[INDEX_W:1], 1'b1} + {{(INDEX_W+1){1'b0}}, l_reg[0] ^ r_reg[0]};
    assign longest = rad_rd_data - RAD_W'(1);
    assign q_width = {1'b0, r_reg} - {1'b0, l_reg} + {{INDEX_W{1'b0}}, 1'b1};

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Next state and datapath updates.
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        ready_next      = ready_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        res_pal_next    = res_pal_reg;
        res_span_next   = res_span_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_func == FUNC_LOAD) begin
                        ready_next = 1'b0;
                        if (in_first) begin
                            len_next = LEN_W'(1);
                        end else if (len_reg != LEN_W'(MAX_LEN)) begin
                            len_next = len_reg + LEN_W'(1);
                        end
                    end else begin
                        l_next = in_start;
                        r_next = in_end;
                        if (in_start > in_end) begin
                            res_pal_next    = 1'b0;
                            res_span_next   = '0;
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_QOUT;
                        end else if (CMP_W'(in_end) >= CMP_W'(len_reg)) begin
                            res_pal_next    = 1'b0;
                            res_span_next   = '0;
                            res_status_next = STATUS_BEYOND;
                            state_next      = ST_QOUT;
                        end else if (ready_reg) begin
                            state_next = ST_QREAD;
                        end else begin
                            state_next = ST_BINIT;
                        end
                    end
                end
            end
            ST_BINIT: begin
                i_next  = IDX_W'(1);
                lo_next = '0;
                hi_next = '0;
                if (pad_len == IDX_W'(1)) begin
                    ready_next = 1'b1;
                    state_next = ST_QREAD;
                end else begin
                    state_next = ST_BMIR;
                end
            end
            ST_BMIR: begin
                if (i_reg < hi_reg) begin
                    state_next = ST_BMWAIT;
                end else begin
                    k_next     = '0;
                    state_next = ST_BEXP;
                end
            end
            ST_BMWAIT: begin
                k_next     = mirror_k;
                state_next = ST_BEXP;
            end
            ST_BEXP: begin
                if ((k_reg > i_reg) || (pos_hi >= pad_len)) begin
                    state_next = ST_BWRITE;
                end else if (!pos_lo[0]) begin
                    // Separators only meet separators.
                    k_next = k_reg + IDX_W'(1);
                end else begin
                    state_next = ST_BCMP;
                end
            end
            ST_BCMP: begin
                if (txt_rd_a == txt_rd_b) begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_BEXP;
                end else begin
                    state_next = ST_BWRITE;
                end
            end
            ST_BWRITE: begin
                if (pos_hi > hi_reg) begin
                    lo_next = pos_lo;
                    hi_next = pos_hi;
                end
                i_next = i_reg + IDX_W'(1);
                if (i_reg + IDX_W'(1) == pad_len) begin
                    ready_next = 1'b1;
                    state_next = ST_QREAD;
                end else begin
                    state_next = ST_BMIR;
                end
            end
            ST_QREAD: begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT: begin
                res_pal_next    = (CMP_W'(longest) >= CMP_W'(q_width));
                res_span_next   = SPAN_W'(longest);
                res_status_next = STATUS_OK;
                state_next      = ST_QOUT;
            end
            ST_QOUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_status_reg, res_span_reg, res_pal_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory control for each state.
    always_comb begin
        txt_wr_en     = 1'b0;
        txt_wr_addr   = in_first ? '0 : TADDR_W'(len_reg);
        txt_rd_en     = 1'b0;
        txt_rd_addr_a = pos_lo[TADDR_W:1];
        txt_rd_addr_b = pos_hi[TADDR_W:1];
        rad_wr_en     = 1'b0;
        rad_wr_addr   = PAD_W'(i_reg);
        rad_wr_data   = RAD_W'(k_reg);
        rad_rd_en     = 1'b0;
        rad_rd_addr   = PAD_W'(mirror_idx);

        case (state_reg)
            ST_IDLE: begin
                txt_wr_en = s_tvalid && (in_func == FUNC_LOAD) &&
                            (in_first || (len_reg != LEN_W'(MAX_LEN)));
            end
            ST_BINIT: begin
                rad_wr_en   = 1'b1;
                rad_wr_addr = '0;
                rad_wr_data = RAD_W'(1);
            end
            ST_BMIR: begin
                rad_rd_en = (i_reg < hi_reg);
            end
            ST_BEXP: begin
                txt_rd_en = !((k_reg > i_reg) || (pos_hi >= pad_len)) && pos_lo[0];
            end
            ST_BWRITE: begin
                rad_wr_en = 1'b1;
            end
            ST_QREAD: begin
                rad_rd_en   = 1'b1;
                rad_rd_addr = PAD_W'(q_pos);
            end
            default: begin
                rad_rd_en = 1'b0;
            end
        endcase
    end

    // Two copies of the text so both ends of an expansion are read in the same cycle.
    prq_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_a (
        .aclk    (aclk),
        .wr_en   (txt_wr_en),
        .wr_addr (txt_wr_addr),
        .wr_data (in_byte),
        .rd_en   (txt_rd_en),
        .rd_addr (txt_rd_addr_a),
        .rd_data (txt_rd_a)
    );

    prq_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_b (
        .aclk    (aclk),
        .wr_en   (txt_wr_en),
        .wr_addr (txt_wr_addr),
        .wr_data (in_byte),
        .rd_en   (txt_rd_en),
        .rd_addr (txt_rd_addr_b),
        .rd_data (txt_rd_b)
    );

    // Radius counts (radius + 1) for every padded position. A mirror read always
    // targets an index below i, which was written in an earlier cycle.
    prq_ram #(.WIDTH(RAD_W), .DEPTH(PDEPTH)) u_radius (
        .aclk    (aclk),
        .wr_en   (rad_wr_en),
        .wr_addr (rad_wr_addr),
        .wr_data (rad_wr_data),
        .rd_en   (rad_rd_en),
        .rd_addr (rad_rd_addr),
        .rd_data (rad_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        k_reg          <= k_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        l_reg          <= l_next;
        r_reg          <= r_next;
        res_pal_reg    <= res_pal_next;
        res_span_reg   <= res_span_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

endmodule
`default_nettype wire

### sim/palindrome_radius_query_core_test.sv
// Self-checking testbench for the palindrome radius query core.
// Drives byte loads and substring queries and compares every result with a built-in predictor.
// Depends on prq_pkg and the core RTL.
`timescale 1ns / 1ps
module palindrome_radius_query_core_test;
    import prq_pkg::*;

    localparam int MAX_LEN = 1024;

    // One predicted query answer.
    typedef struct packed {
        logic        is_palindrome;
        logic [10:0] centre_span;
        logic [1:0]  query_status;
    } query_answer_t;

    // The scoreboard keeps its own copy of the string and predicts answers from it.
    class palindrome_scoreboard;
        logic [7:0]    text_copy [MAX_LEN];
        int            text_len;
        int            radii [2*MAX_LEN+1];
        bit            radii_valid;
        query_answer_t pending_answers [$];
        int            error_count;

        function new();
            text_len = 0;
            radii_valid = 0;
            error_count = 0;
        endfunction

        function bit padded_same(int a, int b);
            if (a % 2 == 0 || b % 2 == 0) return (a % 2 == 0) && (b % 2 == 0);
            return text_copy[(a-1)/2] == text_copy[(b-1)/2];
        endfunction

        // Linear-time palindrome radius pass over the separator-padded text.
        function void rebuild_radii();
            int n, lo, hi, k, m;
            n = 2*text_len + 1;
            lo = 0;
            hi = 0;
            radii[0] = 1;
            for (int i = 1; i < n; i++) begin
                k = 0;
                if (i < hi) begin
                    m = radii[lo + hi - i];
                    k = (hi - i < m) ? hi - i : m;
                end
                while (i - k >= 0 && i + k < n && padded_same(i - k, i + k)) k++;
                radii[i] = k;
                if (i + k > hi) begin
                    lo = i - k;
                    hi = i + k;
                end
            end
            radii_valid = 1;
        endfunction

        function void note_input(logic func, logic first, logic [7:0] b,
                                 logic [9:0] l, logic [9:0] r);
            query_answer_t a;
            int pos, longest;
            if (func == FUNC_LOAD) begin
                if (first) text_len = 0;
                if (text_len < MAX_LEN) begin
                    text_copy[text_len] = b;
                    text_len++;
                end
                radii_valid = 0;
                return;
            end
            a = '0;
            if (l > r) a.query_status = STATUS_EMPTY;
            else if (r >= text_len) a.query_status = STATUS_BEYOND;
            else begin
                if (!radii_valid) rebuild_radii();
                pos = 2*((l + r)/2) + 1 + ((l ^ r) & 1);
                longest = radii[pos] - 1;
                a.is_palindrome = longest >= r - l + 1;
                a.centre_span = longest[10:0];
                a.query_status = STATUS_OK;
            end
            pending_answers.push_back(a);
        endfunction

        function void check_result(logic [15:0] d);
            query_answer_t e;
            if (pending_answers.size() == 0) begin
                $error("unexpected result %h", d);
                error_count++;
                return;
            end
            e = pending_answers.pop_front();
            if (d[0] !== e.is_palindrome) begin
                $error("is_palindrome exp %0d got %0d", e.is_palindrome, d[0]);
                error_count++;
            end
            if (d[11:1] !== e.centre_span) begin
                $error("centre_span exp %0d got %0d", e.centre_span, d[11:1]);
                error_count++;
            end
            if (d[13:12] !== e.query_status) begin
                $error("query_status exp %0d got %0d", e.query_status, d[13:12]);
                error_count++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;

    palindrome_radius_query_core #(.MAX_LEN(MAX_LEN)) dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    palindrome_scoreboard board = new();
    bit stimulus_done = 0;

    // Shadow length so the stimulus can aim queries inside the loaded string.
    int shadow_len = 0;
    // Number of accepted input transactions.
    int sent_count = 0;
    // Cycles the receiver still holds off before the next result.
    int stall_left = 0;

    // Sends one transaction; a random gap first, then hold tvalid until accepted.
    // With no gap tvalid stays high from the previous transaction.
    task automatic send_item(logic func, logic first, logic [7:0] b,
                             logic [9:0] l, logic [9:0] r);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= {first, func};
        s_tdata  <= {4'b0, r, l, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(func, first, b, l, r);
        sent_count++;
        if (func == FUNC_LOAD) begin
            if (first) shadow_len = 1;
            else if (shadow_len < MAX_LEN) shadow_len++;
        end
    endtask

    // Drops tvalid after the last transaction of a burst.
    task automatic idle_input();
        s_tvalid <= 0;
    endtask

    task automatic load_byte(logic first, logic [7:0] b);
        send_item(FUNC_LOAD, first, b, 10'($urandom), 10'($urandom));
    endtask

    task automatic query(logic [9:0] l, logic [9:0] r);
        send_item(FUNC_QUERY, $urandom_range(0, 1), 8'($urandom), l, r);
    endtask

    // Random query that mostly lands inside the string, sometimes mirrored candidates.
    task automatic random_query();
        int l, r, len;
        len = shadow_len;
        case ($urandom_range(0, 9))
            0: query(10'($urandom), 10'($urandom));
            1: begin
                r = $urandom_range(0, 1022);
                query(10'($urandom_range(r + 1, 1023)), 10'(r));
            end
            default: begin
                if (len == 0) query(0, 0);
                else begin
                    l = $urandom_range(0, len - 1);
                    r = $urandom_range(l, len - 1);
                    query(10'(l), 10'(r));
                end
            end
        endcase
    endtask

    // Loads a random string, mostly over a two-symbol alphabet, mirrored into a palindrome half the time.
    task automatic load_string(int len);
        logic [7:0] s [];
        logic [7:0] alpha0, alpha1;
        s = new[len];
        alpha0 = 8'($urandom);
        alpha1 = 8'($urandom);
        for (int i = 0; i < len; i++)
            s[i] = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                   ($urandom_range(0, 1) ? alpha0 : alpha1);
        if ($urandom_range(0, 1))
            for (int i = 0; i < len / 2; i++) s[len - 1 - i] = s[i];
        for (int i = 0; i < len; i++) load_byte(i == 0, s[i]);
    endtask

    // After each result the receiver may drop tready, counting its random hold-off down in stall_left.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_result(m_tdata);
                stall_left = $urandom_range(0, 4);
                if (stall_left != 0) m_tready <= 0;
            end else if (!m_tready) begin
                if (stall_left > 0) stall_left--;
                if (stall_left == 0) m_tready <= 1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty string, extremes, both byte extremes, palindromes odd and even.
        query(0, 0);
        query(10'd1023, 10'd1023);
        load_byte(1, 8'h00);
        load_byte(0, 8'hFF);
        load_byte(0, 8'hFF);
        load_byte(0, 8'h00);
        query(0, 3);
        query(1, 2);
        query(0, 2);
        query(3, 0);
        query(0, 4);
        query(2, 2);
        load_byte(1, 8'hA5);
        query(0, 0);
        load_byte(0, 8'h5A);
        load_byte(0, 8'hA5);
        query(0, 2);
        query(0, 1);
        query(10'd1023, 10'd0);

        // Hold off until every answer is in.
        idle_input();
        @(posedge aclk);
        while (board.pending_answers.size() != 0) @(posedge aclk);

        while (sent_count < 440) begin
            load_string($urandom_range(1, 24));
            repeat ($urandom_range(2, 8)) random_query();
            if ($urandom_range(0, 3) == 0) begin
                load_byte(0, 8'($urandom));
                random_query();
            end
        end
        idle_input();
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        while (board.pending_answers.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.error_count == 0)
            $display("palindrome_radius_query_core_test OK");
        else
            $display("palindrome_radius_query_core_test NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("palindrome_radius_query_core_test NOT OK");
        $finish;
    end
endmodule
